// ===== hdl/pcid_pkg.sv =====
package pcid_pkg;

    // Register map
    localparam logic [0:0] REG_WORKING_POINT = 1'b0;

    // Working points; code three selects tight
    localparam logic [1:0] WP_LOOSE  = 2'd0;
    localparam logic [1:0] WP_MEDIUM = 2'd1;
    localparam logic [1:0] WP_TIGHT  = 2'd2;

    localparam logic REGION_BARREL = 1'b0;
    localparam logic REGION_ENDCAP = 1'b1;

    // Fail bit positions
    localparam int FAIL_HOE = 0;
    localparam int FAIL_SIE = 1;
    localparam int FAIL_CH  = 2;
    localparam int FAIL_NH  = 3;
    localparam int FAIL_PH  = 4;
    localparam int FAIL_W   = 5;

    localparam int SECH_W   = 16;
    localparam int ISO_SHIFT = 14;

    // Q32 constants for the sech table build
    localparam longint unsigned LN2_Q32 = 64'd2977044472;
    localparam longint unsigned ONE_Q32 = 64'd4294967296;

    // Barrel when |sc_eta| * 1000 is below 1480 * 1024
    localparam logic [23:0] REGION_LIM = 24'd1515520;

    // Effective area bins: upper edge * 1024, areas in units of 1/1000
    localparam int EA_ROWS = 7;
    localparam logic [31:0] EDGE_LIM [EA_ROWS] = '{
        32'd1024000, 32'd1514496, 32'd2048000, 32'd2252800,
        32'd2355200, 32'd2457600, 32'd1022976000
    };
    localparam logic [8:0] EA_CH [EA_ROWS] = '{
        9'd12, 9'd10, 9'd14, 9'd12, 9'd16, 9'd20, 9'd12
    };
    localparam logic [8:0] EA_NH [EA_ROWS] = '{
        9'd30, 9'd57, 9'd39, 9'd15, 9'd24, 9'd39, 9'd72
    };
    localparam logic [8:0] EA_PH [EA_ROWS] = '{
        9'd148, 9'd130, 9'd112, 9'd216, 9'd262, 9'd260, 9'd266
    };

    // Cut limits, [region][working point], scaled to the input units
    localparam logic [31:0] HE_LIM [2][3] = '{
        '{32'd204800, 32'd204800, 32'd204800},
        '{32'd204800, 32'd204800, 32'd204800}
    };
    localparam logic [31:0] SIE_LIM [2][3] = '{
        '{32'd786432, 32'd720896, 32'd720896},
        '{32'd2228224, 32'd2162688, 32'd2031616}
    };
    // Isolation limits in MeV times 64
    localparam logic [31:0] CH_LIM [2][3] = '{
        '{32'd166400, 32'd96000, 32'd44800},
        '{32'd147200, 32'd76800, 32'd32000}
    };
    localparam logic [31:0] NH_LIM [2][3] = '{
        '{32'd224000, 32'd64000, 32'd25600},
        '{32'd185600, 32'd96000, 32'd96000}
    };
    localparam logic [31:0] PH_LIM [2][3] = '{
        '{32'd83200, 32'd44800, 32'd32000},
        '{32'd639936000, 32'd64000, 32'd64000}
    };

    // Restoring long division, used only while building constant tables
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        begin
            rem = 64'd0;
            quo = 64'd0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // e^-r in Q32 for 0 <= r < ln2, Taylor series through the r^24 term
    function automatic longint unsigned exp_neg_q32(input longint unsigned r);
        longint          sum;
        longint unsigned term;
        begin
            sum  = longint'(ONE_Q32);
            term = ONE_Q32;
            for (int n = 1; n <= 24; n++)
            begin
                term = udiv64((term * r) >> 32, 64'(n));
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            return longint'(unsigned'(sum));
        end
    endfunction

endpackage

// ===== hdl/pcid_cand_if.sv =====
interface pcid_cand_if;
    logic               valid;
    logic               ready;
    logic [15:0]        energy;
    logic signed [13:0] photon_eta;
    logic signed [13:0] sc_eta;
    logic [15:0]        h_over_e;
    logic [15:0]        sigma_ieta_ieta;
    logic [15:0]        charged_iso;
    logic [15:0]        neutral_iso;
    logic [15:0]        photon_iso;
    logic [11:0]        rho;

    modport source (
        output valid, energy, photon_eta, sc_eta, h_over_e, sigma_ieta_ieta,
               charged_iso, neutral_iso, photon_iso, rho,
        input  ready
    );
    modport sink (
        input  valid, energy, photon_eta, sc_eta, h_over_e, sigma_ieta_ieta,
               charged_iso, neutral_iso, photon_iso, rho,
        output ready
    );
endinterface

// ===== hdl/pcid_result_if.sv =====
interface pcid_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] fail_bits;
    logic       pass_id;
    logic       pass_iso;

    modport source (
        output valid, fail_bits, pass_id, pass_iso,
        input  ready
    );
    modport sink (
        input  valid, fail_bits, pass_id, pass_iso,
        output ready
    );
endinterface

// ===== hdl/pcid_sech_rom.sv =====
module pcid_sech_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [15:0]              data
);
    import pcid_pkg::*;

    typedef logic [SECH_W-1:0] rom_t [DEPTH];

    // Entry i is sech(8*i/DEPTH) in Q0.16, rounded to nearest
    function automatic logic [SECH_W-1:0] sech_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned k;
        longint unsigned r;
        longint unsigned y;
        longint unsigned yy;
        longint unsigned den;
        longint unsigned s;
        begin
            if (i == 0)
                return {SECH_W{1'b1}};
            x = udiv64(((64'(i) * 64'd8) << 32) + (64'(DEPTH) >> 1), 64'(DEPTH));
            k = udiv64(x, LN2_Q32);
            r = x - k * LN2_Q32;
            y = exp_neg_q32(r);
            if (k > 0)
                y = (y + (64'd1 << (k - 1))) >> k;
            if (y >= ONE_Q32)
                y = ONE_Q32 - 64'd1;
            yy  = (y * y) >> 32;
            den = ONE_Q32 + yy;
            s   = udiv64((y << 17) + (den >> 1), den);
            return (s > 64'd65535) ? {SECH_W{1'b1}} : s[SECH_W-1:0];
        end
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        begin
            for (int i = 0; i < DEPTH; i++)
                t[i] = sech_entry(i);
            return t;
        end
    endfunction

    localparam rom_t SECH_ROM = build_rom();

    logic [SECH_W-1:0] data_reg;

    // Registered read; hold while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SECH_ROM[addr];
    end

    assign data = data_reg;

endmodule

// ===== hdl/photon_cut_identification.sv =====
// Cut-based photon identification with effective-area isolation. Each word on
// the cand channel is one photon candidate with its event rho; each word on
// the result channel gives the five fail bits (H/E, sigma-ieta-ieta, charged,
// neutral, photon isolation) with pass_id and pass_iso. The block is a
// four-stage pipeline and takes one candidate every clock unless back
// pressure stalls it; the result word passes through stages one to four
// in order and leaves when the result side is ready.
// Stage one takes |eta|, the sech table address and the region; stage two
// reads the sech table (a block ROM with registered read, SECH_TABLE_DEPTH
// entries built at elaboration), picks the effective areas from the first
// of up to EA_BINS |eta| bins and applies the shower-shape cuts; stage three
// forms pt = energy * sech and the rho-corrected isolation sums; stage four
// compares them against the pt-dependent limits into the output register.
// Back pressure stalls only the stages behind a full stage, so bubbles are
// squeezed out. The APB port holds one register, working_point at byte 0
// (0 loose, 1 medium, 2 tight, 3 acts as tight); write it only while the
// pipeline is empty.
module photon_cut_identification #(
    parameter int SECH_TABLE_DEPTH = 1024,
    parameter int EA_BINS          = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    pcid_cand_if.sink     cand,
    pcid_result_if.source result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import pcid_pkg::*;

    localparam int AW  = $clog2(SECH_TABLE_DEPTH);
    localparam int IPW = 14 + $clog2(SECH_TABLE_DEPTH + 1);

    // Stage one word
    typedef struct packed {
        logic [15:0]   energy;
        logic [AW-1:0] idx;
        logic [23:0]   seta1000;
        logic          region;
        logic [25:0]   hoe1000;
        logic [25:0]   sie1000;
        logic [15:0]   ch;
        logic [15:0]   nh;
        logic [15:0]   ph;
        logic [11:0]   rho;
    } stage_a_t;

    // Stage two word; the sech value sits in the ROM output register
    typedef struct packed {
        logic [15:0] energy;
        logic        region;
        logic [8:0]  ea_ch;
        logic [8:0]  ea_nh;
        logic [8:0]  ea_ph;
        logic [11:0] rho;
        logic [25:0] ch1000;
        logic [25:0] nh1000;
        logic [25:0] ph1000;
        logic        fail_hoe;
        logic        fail_sie;
    } stage_b_t;

    // Stage three word
    typedef struct packed {
        logic [31:0]        pt;
        logic               region;
        logic signed [26:0] d_ch;
        logic signed [26:0] d_nh;
        logic signed [26:0] d_ph;
        logic               fail_hoe;
        logic               fail_sie;
    } stage_c_t;

    function automatic logic [13:0] abs14(input logic signed [13:0] v);
        begin
            return v[13] ? (~v + 14'd1) : v;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    logic [1:0] wp_reg;
    logic [1:0] wp_next;
    logic [1:0] wp_eff;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        wp_next = wp_reg;
        if (cfg_write && (paddr[2] == REG_WORKING_POINT))
            wp_next = pwdata[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wp_reg <= WP_LOOSE;
        else
            wp_reg <= wp_next;
    end

    assign prdata = (paddr[2] == REG_WORKING_POINT) ? {30'd0, wp_reg} : 32'd0;
    // Code three selects the tight cuts
    assign wp_eff = (wp_reg > WP_TIGHT) ? WP_TIGHT : wp_reg;

    // ---------------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or the
    // stage after it advances
    // ---------------------------------------------------------------------
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic va_next, vb_next, vc_next, vd_next;
    logic en_a, en_b, en_c, en_d;

    assign en_d = !vd_reg || result.ready;
    assign en_c = !vc_reg || en_d;
    assign en_b = !vb_reg || en_c;
    assign en_a = !va_reg || en_b;

    assign cand.ready = en_a;

    assign va_next = en_a ? cand.valid : va_reg;
    assign vb_next = en_b ? va_reg     : vb_reg;
    assign vc_next = en_c ? vb_reg     : vc_reg;
    assign vd_next = en_d ? vc_reg     : vd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vd_reg <= vd_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage one: |eta|, sech address, region, shower-shape scaling
    // ---------------------------------------------------------------------
    stage_a_t        a_reg;
    stage_a_t        a_next;
    logic [13:0]     peta_abs;
    logic [13:0]     seta_abs;
    logic [IPW-1:0]  idx_prod;
    logic [IPW-14:0] idx_full;

    always_comb
    begin
        peta_abs = abs14(cand.photon_eta);
        seta_abs = abs14(cand.sc_eta);
        // Table bin lower edge: |eta| * depth / 8192, top magnitude saturates
        idx_prod = IPW'(peta_abs) * IPW'(SECH_TABLE_DEPTH);
        idx_full = idx_prod[IPW-1:13];

        a_next.energy   = cand.energy;
        a_next.idx      = (idx_full >= (IPW-13)'(SECH_TABLE_DEPTH))
                        ? AW'(SECH_TABLE_DEPTH - 1) : idx_full[AW-1:0];
        a_next.seta1000 = 24'(seta_abs) * 24'd1000;
        a_next.region   = (a_next.seta1000 < REGION_LIM) ? REGION_BARREL
                                                         : REGION_ENDCAP;
        a_next.hoe1000  = 26'(cand.h_over_e) * 26'd1000;
        a_next.sie1000  = 26'(cand.sigma_ieta_ieta) * 26'd1000;
        a_next.ch       = cand.charged_iso;
        a_next.nh       = cand.neutral_iso;
        a_next.ph       = cand.photon_iso;
        a_next.rho      = cand.rho;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
            a_reg <= a_next;
    end

    // ---------------------------------------------------------------------
    // Stage two: sech read, effective-area bin, shower-shape cuts
    // ---------------------------------------------------------------------
    logic [15:0] sech_data;

    pcid_sech_rom #(
        .DEPTH(SECH_TABLE_DEPTH)
    ) u_sech_rom (
        .clk  (clk),
        .en   (en_b),
        .addr (a_reg.idx),
        .data (sech_data)
    );

    stage_b_t b_reg;
    stage_b_t b_next;

    always_comb
    begin
        b_next.energy = a_reg.energy;
        b_next.region = a_reg.region;
        b_next.rho    = a_reg.rho;
        // No bin above eta leaves the areas at zero
        b_next.ea_ch  = 9'd0;
        b_next.ea_nh  = 9'd0;
        b_next.ea_ph  = 9'd0;
        // Walk down so the first matching bin wins
        for (int i = EA_ROWS - 1; i >= 0; i--)
        begin
            if ((i < EA_BINS) && (EDGE_LIM[i] > 32'(a_reg.seta1000)))
            begin
                b_next.ea_ch = EA_CH[i];
                b_next.ea_nh = EA_NH[i];
                b_next.ea_ph = EA_PH[i];
            end
        end
        b_next.ch1000   = 26'(a_reg.ch) * 26'd1000;
        b_next.nh1000   = 26'(a_reg.nh) * 26'd1000;
        b_next.ph1000   = 26'(a_reg.ph) * 26'd1000;
        b_next.fail_hoe = 32'(a_reg.hoe1000) > HE_LIM[a_reg.region][wp_eff];
        b_next.fail_sie = 32'(a_reg.sie1000) > SIE_LIM[a_reg.region][wp_eff];
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            b_reg <= b_next;
    end

    // ---------------------------------------------------------------------
    // Stage three: pt and rho-corrected isolation sums
    // ---------------------------------------------------------------------
    stage_c_t    c_reg;
    stage_c_t    c_next;
    logic [20:0] rho_ea_ch;
    logic [20:0] rho_ea_nh;
    logic [20:0] rho_ea_ph;

    always_comb
    begin
        rho_ea_ch = 21'(b_reg.rho) * 21'(b_reg.ea_ch);
        rho_ea_nh = 21'(b_reg.rho) * 21'(b_reg.ea_nh);
        rho_ea_ph = 21'(b_reg.rho) * 21'(b_reg.ea_ph);

        c_next.pt       = 32'(b_reg.energy) * 32'(sech_data);
        c_next.region   = b_reg.region;
        // Corrected sums may go negative
        c_next.d_ch     = 27'(b_reg.ch1000) - 27'(rho_ea_ch);
        c_next.d_nh     = 27'(b_reg.nh1000) - 27'(rho_ea_nh);
        c_next.d_ph     = 27'(b_reg.ph1000) - 27'(rho_ea_ph);
        c_next.fail_hoe = b_reg.fail_hoe;
        c_next.fail_sie = b_reg.fail_sie;
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
            c_reg <= c_next;
    end

    // ---------------------------------------------------------------------
    // Stage four: isolation cuts against pt-dependent limits
    // Compare in units of 1/(64000 * 2^14) GeV: 0.04 pt is 40 * pt_raw,
    // 0.005 pt is 5 * pt_raw
    // ---------------------------------------------------------------------
    logic signed [47:0] lhs_ch, lhs_nh, lhs_ph;
    logic signed [47:0] rhs_ch, rhs_nh, rhs_ph;
    logic [47:0]        pt_w;
    logic [FAIL_W-1:0]  fail_reg;
    logic [FAIL_W-1:0]  fail_next;

    always_comb
    begin
        pt_w   = 48'(c_reg.pt);
        lhs_ch = 48'(c_reg.d_ch);
        rhs_ch = 48'(CH_LIM[c_reg.region][wp_eff]);
        lhs_nh = 48'(c_reg.d_nh) <<< ISO_SHIFT;
        rhs_nh = (48'(NH_LIM[c_reg.region][wp_eff]) << ISO_SHIFT)
               + (pt_w << 5) + (pt_w << 3);
        lhs_ph = 48'(c_reg.d_ph) <<< ISO_SHIFT;
        rhs_ph = (48'(PH_LIM[c_reg.region][wp_eff]) << ISO_SHIFT)
               + (pt_w << 2) + pt_w;

        fail_next           = '0;
        fail_next[FAIL_HOE] = c_reg.fail_hoe;
        fail_next[FAIL_SIE] = c_reg.fail_sie;
        fail_next[FAIL_CH]  = lhs_ch > rhs_ch;
        fail_next[FAIL_NH]  = lhs_nh > rhs_nh;
        fail_next[FAIL_PH]  = lhs_ph > rhs_ph;
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
            fail_reg <= fail_next;
    end

    assign result.valid     = vd_reg;
    assign result.fail_bits = fail_reg;
    assign result.pass_id   = !(fail_reg[FAIL_HOE] || fail_reg[FAIL_SIE]);
    assign result.pass_iso  = !(fail_reg[FAIL_CH] || fail_reg[FAIL_NH]
                                || fail_reg[FAIL_PH]);

endmodule

// ===== hdl/pcid_checker.sv =====
module pcid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [4:0]  fail_bits,
    input logic        pass_id,
    input logic        pass_iso,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import pcid_pkg::*;

    // Shower-shape summary agrees with its fail bits
    a_pass_id : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pass_id == !(fail_bits[FAIL_HOE] || fail_bits[FAIL_SIE])))
        else $error("pass_id disagrees with shower-shape fail bits");

    // Isolation summary agrees with its fail bits
    a_pass_iso : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pass_iso == !(fail_bits[FAIL_CH] || fail_bits[FAIL_NH]
                                     || fail_bits[FAIL_PH])))
        else $error("pass_iso disagrees with isolation fail bits");

    // Hold a stalled result word
    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result word dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> $stable({fail_bits, pass_id, pass_iso}))
        else $error("result word changed while stalled");

    // A write to the working point reads back on the next cycle
    a_cfg_readback : assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_WORKING_POINT))
        |=> ((paddr[2] != REG_WORKING_POINT)
             || (prdata[1:0] == $past(pwdata[1:0]))))
        else $error("working point read back mismatch");

endmodule

bind photon_cut_identification pcid_checker u_pcid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .fail_bits (result.fail_bits),
    .pass_id   (result.pass_id),
    .pass_iso  (result.pass_iso),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
